[rtl/core/sha256_pkg.sv]
// types, constants and a rotate function for the sha-256 stream hasher
// shared by the front, the queue, the compression engine and the top level
package sha256_pkg;

    localparam int unsigned QueueDepth = 4;

    // request carried from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_req;

    localparam int unsigned ReqWidth = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD2,
        ST_EMIT
    } t_state;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
        ror = (v >> s) | (v << (32 - s));
    endfunction

endpackage

[rtl/core/sha256_front.sv]
// input side: takes stream requests and packs them for the queue
// uses sha256_pkg; drops requests that carry neither byte nor end flag
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_byte_valid,
    input  logic                i_end_of_message,
    output logic                o_push,
    output sha256_pkg::t_req    o_req,
    input  logic                i_full
);
    logic r_unused;
    logic n_unused;

    assign o_ready = !i_full;

    // classify: empty requests are consumed without effect
    always_comb begin
        o_req.data_byte      = i_data_byte;
        o_req.byte_valid     = i_byte_valid;
        o_req.end_of_message = i_end_of_message;
        o_push = i_valid && !i_full && (i_byte_valid || i_end_of_message);
        n_unused = r_unused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unused <= 1'b0;
        end else begin
            r_unused <= n_unused;
        end
    end
endmodule

[rtl/core/sha256_fifo.sv]
// short request queue between front and back
// uses sha256_pkg for depth and request width
module sha256_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  sha256_pkg::t_req          i_req,
    output logic                      o_full,
    input  logic                      i_pop,
    output sha256_pkg::t_req          o_req,
    output logic                      o_empty
);
    localparam int unsigned AW = $clog2(sha256_pkg::QueueDepth);

    sha256_pkg::t_req r_mem [sha256_pkg::QueueDepth];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(sha256_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[rtl/core/sha256_engine.sv]
// back side: block buffer, padding, 64-round compression and digest output
// uses sha256_pkg for constants, state type and rotate function
module sha256_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_req    i_req,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_word,
    output logic [2:0]          o_index,
    output logic                o_last
);
    sha256_pkg::t_state r_state, n_state;
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [60:0] r_cnt;
    logic [5:0]  r_t;
    logic        r_final;
    logic        r_two;
    logic [2:0]  r_idx;

    logic [5:0]  cnt_lo;
    logic [60:0] cnt_inc;
    logic        take;
    logic        blk_full;
    logic [31:0] w_new, t1, t2, wt, e, a;
    logic [63:0] bits;
    logic [63:0] len_bits;
    logic [5:0]  rem;
    logic [31:0] w_load [16];

    assign cnt_lo  = r_cnt[5:0];
    assign cnt_inc = r_cnt + 61'd1;
    assign take    = (r_state == sha256_pkg::ST_IDLE) && !i_empty;
    assign o_pop   = take;
    assign rem     = i_req.byte_valid ? cnt_inc[5:0] : cnt_lo;
    assign blk_full = i_req.byte_valid && (cnt_lo == 6'd63);
    assign len_bits = i_req.byte_valid ? {cnt_inc, 3'b000} : bits;

    // round datapath
    always_comb begin
        logic [31:0] w15, w2;
        w15 = r_w[1];
        w2  = r_w[14];
        w_new = r_w[0] + (sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3))
              + r_w[9] + (sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10));
        wt = r_w[0];
        a  = r_v[0];
        e  = r_v[4];
        t1 = r_v[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha256_pkg::K_TABLE[r_t] + wt;
        t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // block buffer contents after taking a request: new byte, padding and length
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_load[j] = r_w[j];
        end
        if (i_req.byte_valid) begin
            w_load[cnt_lo[5:2]][8*(3-cnt_lo[1:0]) +: 8] = i_req.data_byte;
        end
        if (i_req.end_of_message && !blk_full) begin
            // pad the tail of the open block
            for (int wi = 0; wi < 16; wi++) begin
                for (int bi = 0; bi < 4; bi++) begin
                    if ({wi[3:0], bi[1:0]} == rem) begin
                        w_load[wi][8*(3-bi) +: 8] = sha256_pkg::PAD_BYTE;
                    end else if ({wi[3:0], bi[1:0]} > rem) begin
                        w_load[wi][8*(3-bi) +: 8] = 8'h00;
                    end
                end
            end
            if (rem < 6'd56) begin
                w_load[14] = len_bits[63:32];
                w_load[15] = len_bits[31:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (take && (blk_full || i_req.end_of_message)) begin
                    n_state = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_t == 6'd63) begin
                    n_state = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD: begin
                if (!r_final) begin
                    n_state = sha256_pkg::ST_IDLE;
                end else if (r_two) begin
                    n_state = sha256_pkg::ST_PAD2;
                end else begin
                    n_state = sha256_pkg::ST_EMIT;
                end
            end
            sha256_pkg::ST_PAD2: begin
                n_state = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_EMIT: begin
                if (i_ready && (r_idx == 3'd7)) begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_valid = (r_state == sha256_pkg::ST_EMIT);
        o_word  = r_h[r_idx];
        o_index = r_idx;
        o_last  = (r_idx == 3'd7);
    end

    assign bits = {r_cnt, 3'b000};

    // datapath registers; schedule words double as the block buffer
    always_ff @(posedge i_clk) begin
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (take) begin
                    for (int j = 0; j < 16; j++) begin
                        r_w[j] <= w_load[j];
                    end
                    if (blk_full || i_req.end_of_message) begin
                        for (int j = 0; j < 8; j++) begin
                            r_v[j] <= r_h[j];
                        end
                    end
                end
            end
            sha256_pkg::ST_ROUND: begin
                for (int j = 0; j < 15; j++) begin
                    r_w[j] <= r_w[j+1];
                end
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= e;
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= a;
                r_v[0] <= t1 + t2;
            end
            sha256_pkg::ST_PAD2: begin
                // a message ending on a block boundary starts this block with the pad byte
                r_w[0] <= (cnt_lo == 6'd0) ? {sha256_pkg::PAD_BYTE, 24'h000000} : 32'h0;
                for (int j = 1; j < 14; j++) begin
                    r_w[j] <= '0;
                end
                r_w[14] <= bits[63:32];
                r_w[15] <= bits[31:0];
                for (int j = 0; j < 8; j++) begin
                    r_v[j] <= r_h[j];
                end
            end
            default: ;
        endcase
    end

    // control registers and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_t     <= '0;
            r_final <= 1'b0;
            r_two   <= 1'b0;
            r_idx   <= '0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= sha256_pkg::H_INIT[j];
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                sha256_pkg::ST_IDLE: begin
                    r_t <= '0;
                    if (take) begin
                        if (i_req.byte_valid) begin
                            r_cnt <= cnt_inc;
                        end
                        r_final <= i_req.end_of_message;
                        r_two   <= i_req.end_of_message && (blk_full || rem >= 6'd56);
                    end
                end
                sha256_pkg::ST_ROUND: r_t <= r_t + 6'd1;
                sha256_pkg::ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                    r_idx <= '0;
                end
                sha256_pkg::ST_PAD2: begin
                    r_two <= 1'b0;
                    r_t   <= '0;
                end
                sha256_pkg::ST_EMIT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_cnt <= '0;
                            for (int j = 0; j < 8; j++) begin
                                r_h[j] <= sha256_pkg::H_INIT[j];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/sha256_stream_hasher_core.sv]
// top level of the sha-256 stream hasher
// instantiates sha256_front, sha256_fifo and sha256_engine; uses sha256_pkg
//
// Bytes enter one per request; a request closing a 64-byte block starts the
// compression engine (one load, 64 rounds, one add), while other byte requests
// are only stored in the block buffer. Closing a message takes one or two such
// blocks and then the eight digest words are emitted. A
// four-entry queue lets the input keep taking bytes while a block compresses.
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word, word_index, zero fill
    output logic        m_axis_tlast    // last_word
);
    sha256_pkg::t_req front_req;
    sha256_pkg::t_req back_req;
    logic push, full, pop, empty;
    logic [31:0] word;
    logic [2:0]  idx;

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data_byte(s_axis_tdata), .i_byte_valid(s_axis_tuser[0]),
        .i_end_of_message(s_axis_tlast),
        .o_push(push), .o_req(front_req), .i_full(full)
    );

    sha256_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_req(front_req), .o_full(full),
        .i_pop(pop), .o_req(back_req), .o_empty(empty)
    );

    sha256_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(back_req), .i_empty(empty), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(word), .o_index(idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, idx, word};
endmodule

[tb/tb_sha256_stream_hasher_core.sv]
// self-checking testbench for the sha-256 stream hasher core
// needs sha256_stream_hasher_core and sha256_pkg; predicts digests with its own sha-256 model
module tb_sha256_stream_hasher_core;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic [1:0]  s_axis_tuser;   // byte_valid, zero fill
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // digest_word, word_index, zero fill
    logic        m_axis_tlast;   // last_word

    sha256_stream_hasher_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // own copy of the hashing state
    logic [31:0]  chain_h [8];
    logic [7:0]   msg_block [64];
    logic [60:0]  msg_len;
    t_digest_word pending_digest_words [$];

    int errors;
    int items_sent;
    int messages_closed;
    int words_checked;
    bit no_idle;
    int rx_wait;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #8000000;
        $display("timeout at %0t", $realtime);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    // one sha-256 compression of msg_block into chain_h
    function automatic void compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 0; j < 8; j++) v[j] = chain_h[j];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
                s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
                wt = w[t%16] + s0 + w[(t-7)%16] + s1;
                w[t%16] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K_TABLE[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain_h[j] += v[j];
    endfunction

    // update the model for one accepted request and queue any digest
    function automatic void predict_digest(input logic [7:0] d, input bit bv, input bit eom);
        logic [5:0]  fill;
        logic [63:0] bits;
        t_digest_word dw;
        if (bv) begin
            msg_block[msg_len[5:0]] = d;
            msg_len = msg_len + 1'b1;
            if (msg_len[5:0] == 6'd0) compress_msg_block();
        end
        if (!eom) return;
        fill = msg_len[5:0];
        msg_block[fill] = sha256_pkg::PAD_BYTE;
        for (int j = fill + 1; j < 64; j++) msg_block[j] = 8'h00;
        if (fill >= 56) begin
            compress_msg_block();
            for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
        end
        bits = {msg_len, 3'b000};
        for (int j = 0; j < 8; j++) msg_block[63-j] = bits[8*j +: 8];
        compress_msg_block();
        for (int j = 0; j < 8; j++) begin
            dw.word = chain_h[j];
            dw.idx  = 3'(j);
            dw.last = (j == 7);
            pending_digest_words = {pending_digest_words, dw};
        end
        for (int j = 0; j < 8; j++) chain_h[j] = sha256_pkg::H_INIT[j];
        msg_len = '0;
        messages_closed++;
    endfunction

    function automatic int draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 18);
    endfunction

    // send one request and wait for its acceptance
    task automatic send_item(input logic [7:0] d, input bit bv, input bit eom);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {1'b0, bv};
        s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digest(d, bv, eom);
        items_sent++;
    endtask

    // a message of random bytes, with occasional empty requests mixed in
    task automatic send_message(input int len, input bit eom_on_last);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, eom_on_last && (n == len - 1));
        end
        if (!eom_on_last || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // result check
    always @(posedge i_clk) begin
        t_digest_word dw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_digest_words.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $realtime, m_axis_tdata);
                    errors++;
                end else begin
                    dw = pending_digest_words.pop_front();
                    words_checked++;
                    if (m_axis_tdata[31:0] !== dw.word) begin
                        $display("%0t: digest_word exp %h got %h",
                                 $realtime, dw.word, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[34:32] !== dw.idx) begin
                        $display("%0t: word_index exp %0d got %0d",
                                 $realtime, dw.idx, m_axis_tdata[34:32]);
                        errors++;
                    end
                    if (m_axis_tdata[39:35] !== 5'd0) begin
                        $display("%0t: zero fill exp 0 got %h", $realtime, m_axis_tdata[39:35]);
                        errors++;
                    end
                    if (m_axis_tlast !== dw.last) begin
                        $display("%0t: last_word exp %0b got %0b",
                                 $realtime, dw.last, m_axis_tlast);
                        errors++;
                    end
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // empty message, ignored requests and short messages with extreme bytes
    task automatic test_directed();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'ha5, 1'b1, 1'b1);
    endtask

    // lengths around the padding and block boundaries
    function automatic int draw_length();
        int edges [12] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128, 0};
        if ($urandom_range(0, 1) == 0) return edges[$urandom_range(0, 11)];
        return $urandom_range(0, 12);
    endfunction

    task automatic test_random_messages(input int budget);
        int start;
        int len;
        int room;
        start = items_sent;
        while (items_sent - start < budget) begin
            no_idle = ($urandom_range(0, 4) == 0);
            len  = draw_length();
            room = budget - (items_sent - start);
            if (len > room) len = room;
            send_message(len, $urandom_range(0, 1));
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until every digest has come out
    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        wait (pending_digest_words.size() == 0);
        @(posedge i_clk);
        send_message(3, 1'b1);
    endtask

    initial begin
        errors = 0; items_sent = 0; messages_closed = 0; words_checked = 0;
        no_idle = 1'b0;
        for (int j = 0; j < 8; j++) chain_h[j] = sha256_pkg::H_INIT[j];
        msg_len = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 2'b00;
        s_axis_tlast  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_messages(180);
        test_drain_pause();
        test_random_messages(180);

        s_axis_tvalid <= 1'b0;
        wait (pending_digest_words.size() == 0);
        repeat (300) @(posedge i_clk);

        $display("sent %0d requests closing %0d messages, checked %0d digest words",
                 items_sent, messages_closed, words_checked);
        $display("lengths near every padding and block boundary, with random stalls");
        if (errors == 0 && pending_digest_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sha256_pkg.sv
rtl/core/sha256_front.sv
rtl/core/sha256_fifo.sv
rtl/core/sha256_engine.sv
rtl/core/sha256_stream_hasher_core.sv
tb/tb_sha256_stream_hasher_core.sv
